>>> design/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types, register indexes, reset values and codes for the serial link
// supervisor.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_IDX_WIDTH   = 3;
  localparam int GAP_WIDTH       = 8;

  localparam logic [CFG_IDX_WIDTH-1:0] IDX_OFFLINE_TICKS = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] IDX_FIRST_RESET   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] IDX_RETRY_RESET   = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] IDX_FRAME_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] IDX_POLL_GAP      = 3'd4;

  localparam logic [CFG_WIDTH-1:0] RST_OFFLINE_TICKS = 16'd500;
  localparam logic [CFG_WIDTH-1:0] RST_FIRST_RESET   = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] RST_RETRY_RESET   = 16'd100;
  localparam logic [CFG_WIDTH-1:0] RST_FRAME_TIMEOUT = 16'd50;
  localparam logic [GAP_WIDTH-1:0] RST_POLL_GAP      = 8'd1;

  localparam logic [1:0] PR_BUSY   = 2'd0;
  localparam logic [1:0] PR_OK     = 2'd1;
  localparam logic [1:0] PR_FAIL   = 2'd2;
  localparam logic [1:0] PR_NONE   = 2'd3;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] offline_ticks;
    logic [CFG_WIDTH-1:0] first_reset_ticks;
    logic [CFG_WIDTH-1:0] retry_reset_ticks;
    logic [CFG_WIDTH-1:0] frame_timeout_ticks;
    logic [GAP_WIDTH-1:0] poll_gap_ticks;
  } sls_cfg_t;

  typedef struct packed {
    logic link_online;
    logic reset_receive;
    logic parser_polled;
  } sls_res_t;

endpackage

>>> design/sls_cfg_regs.sv
// ----------------------------------------------------------------------------
// sls_cfg_regs
// Configuration register file: write-only, indexed, reset to default timings.
// ----------------------------------------------------------------------------
module sls_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sls_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [sls_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  output sls_pkg::sls_cfg_t                 cfg
);
  import sls_pkg::*;

  sls_cfg_t cfg_r;
  sls_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        IDX_OFFLINE_TICKS: cfg_nxt.offline_ticks       = cfg_wdata;
        IDX_FIRST_RESET:   cfg_nxt.first_reset_ticks   = cfg_wdata;
        IDX_RETRY_RESET:   cfg_nxt.retry_reset_ticks   = cfg_wdata;
        IDX_FRAME_TIMEOUT: cfg_nxt.frame_timeout_ticks = cfg_wdata;
        IDX_POLL_GAP:      cfg_nxt.poll_gap_ticks      = cfg_wdata[GAP_WIDTH-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offline_ticks       <= RST_OFFLINE_TICKS;
      cfg_r.first_reset_ticks   <= RST_FIRST_RESET;
      cfg_r.retry_reset_ticks   <= RST_RETRY_RESET;
      cfg_r.frame_timeout_ticks <= RST_FRAME_TIMEOUT;
      cfg_r.poll_gap_ticks      <= RST_POLL_GAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/sls_core.sv
// ----------------------------------------------------------------------------
// sls_core
// Supervisor state and per-tick update: timer countdown, idle watchdog,
// frame timeout and parser polling.
// ----------------------------------------------------------------------------
module sls_core #(
  parameter int TIMER_WIDTH = sls_pkg::TIMER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sls_pkg::sls_cfg_t cfg,
  input  logic              step,
  input  logic              rx_pending,
  input  logic [1:0]        parse_result,
  output sls_pkg::sls_res_t res
);
  import sls_pkg::*;

  localparam logic [1:0] WS_ARM   = 2'd0;
  localparam logic [1:0] WS_WAIT  = 2'd1;
  localparam logic [1:0] WS_RETRY = 2'd2;

  logic [1:0]             watch_step_r, watch_step_nxt;
  logic [TIMER_WIDTH-1:0] offline_timer_r, offline_timer_nxt;
  logic [TIMER_WIDTH-1:0] reset_timer_r, reset_timer_nxt;
  logic [TIMER_WIDTH-1:0] frame_timer_r, frame_timer_nxt;
  logic [GAP_WIDTH-1:0]   poll_timer_r, poll_timer_nxt;
  logic                   frame_armed_r, frame_armed_nxt;
  logic                   online_r, online_nxt;
  logic                   do_reset;
  logic                   polled;

  always_comb begin
    frame_timer_nxt   = frame_timer_r - TIMER_WIDTH'(frame_timer_r != '0);
    poll_timer_nxt    = poll_timer_r - GAP_WIDTH'(poll_timer_r != '0);
    offline_timer_nxt = offline_timer_r - TIMER_WIDTH'(offline_timer_r != '0);
    reset_timer_nxt   = reset_timer_r - TIMER_WIDTH'(reset_timer_r != '0);
    watch_step_nxt    = watch_step_r;
    frame_armed_nxt   = frame_armed_r;
    online_nxt        = online_r;
    do_reset          = 1'b0;
    polled            = 1'b0;

    if (!rx_pending) begin
      case (watch_step_r)
        WS_ARM: begin
          offline_timer_nxt = TIMER_WIDTH'(cfg.offline_ticks);
          watch_step_nxt    = WS_WAIT;
        end
        WS_WAIT: begin
          if (offline_timer_nxt == '0) begin
            online_nxt      = 1'b0;
            watch_step_nxt  = WS_RETRY;
            reset_timer_nxt = TIMER_WIDTH'(cfg.first_reset_ticks);
            do_reset        = 1'b1;
          end
        end
        WS_RETRY: begin
          if (reset_timer_nxt == '0) begin
            do_reset        = 1'b1;
            reset_timer_nxt = TIMER_WIDTH'(cfg.retry_reset_ticks);
          end
        end
        default: watch_step_nxt = watch_step_r;
      endcase
    end else begin
      offline_timer_nxt = '0;
      watch_step_nxt    = WS_ARM;
      online_nxt        = 1'b1;
      if (frame_armed_r && frame_timer_nxt == '0) begin
        do_reset = 1'b1;
      end else if (poll_timer_nxt == '0) begin
        polled = 1'b1;
        case (parse_result)
          PR_BUSY: begin
            poll_timer_nxt = cfg.poll_gap_ticks;
            if (!frame_armed_r) begin
              frame_armed_nxt = 1'b1;
              frame_timer_nxt = TIMER_WIDTH'(cfg.frame_timeout_ticks);
            end
          end
          PR_OK, PR_FAIL: do_reset = 1'b1;
          default:        do_reset = 1'b0;
        endcase
      end
    end

    if (do_reset) begin
      poll_timer_nxt  = '0;
      frame_armed_nxt = 1'b0;
      frame_timer_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_step_r    <= WS_ARM;
      offline_timer_r <= '0;
      reset_timer_r   <= '0;
      frame_timer_r   <= '0;
      poll_timer_r    <= '0;
      frame_armed_r   <= 1'b0;
      online_r        <= 1'b0;
    end else if (step) begin
      watch_step_r    <= watch_step_nxt;
      offline_timer_r <= offline_timer_nxt;
      reset_timer_r   <= reset_timer_nxt;
      frame_timer_r   <= frame_timer_nxt;
      poll_timer_r    <= poll_timer_nxt;
      frame_armed_r   <= frame_armed_nxt;
      online_r        <= online_nxt;
    end
  end

  assign res.link_online   = online_nxt;
  assign res.reset_receive = do_reset;
  assign res.parser_polled = polled;

  a_reset_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    step && do_reset |=> !frame_armed_r && poll_timer_r == '0)
    else $error("receive reset left frame timeout armed");

  a_poll_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    step && polled |-> rx_pending)
    else $error("parser polled without pending data");

  a_online_on_data: assert property (@(posedge clk) disable iff (!rst_n)
    step && rx_pending |=> online_r && watch_step_r == WS_ARM)
    else $error("pending data did not bring link online");

  a_armed_timer: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_armed_r |-> frame_timer_r == '0)
    else $error("frame timer running while disarmed");

endmodule

>>> design/serial_link_supervisor.sv
// ----------------------------------------------------------------------------
// serial_link_supervisor
// Tick-driven receive link supervisor with idle watchdog and frame timeout.
// ----------------------------------------------------------------------------
// One input word is one tick and yields exactly one result word. A word is
// registered on entry, evaluated against the supervisor state by
// combinational logic, and lands in an output register, so a new word is
// taken every cycle while the output is not stalled. A stalled result holds
// the entered word in its register and raises in_stall. Configuration takes
// effect on the next word.
module serial_link_supervisor #(
  parameter int TIMER_WIDTH = sls_pkg::TIMER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sls_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [sls_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_rx_pending,
  input  logic [1:0]                        in_parse_result,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_link_online,
  output logic                              out_reset_receive,
  output logic                              out_parser_polled
);
  import sls_pkg::*;

  sls_cfg_t   cfg;
  sls_res_t   res;
  logic       item_valid_r;
  logic       item_pending_r;
  logic [1:0] item_result_r;
  logic       out_valid_r;
  sls_res_t   out_res_r;
  logic       advance;
  logic       accept;
  logic       step;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign step     = item_valid_r && advance;

  sls_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sls_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .step         (step),
    .rx_pending   (item_pending_r),
    .parse_result (item_result_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (accept) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_pending_r <= in_rx_pending;
      item_result_r  <= in_parse_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_link_online   = out_res_r.link_online;
  assign out_reset_receive = out_res_r.reset_receive;
  assign out_parser_polled = out_res_r.parser_polled;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !step)
    else $error("result overwritten while stalled");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !advance |=> item_valid_r && $stable(item_result_r))
    else $error("held word lost");

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("evaluated word produced no result");

endmodule
